### src/text_console_char_engine_core_defines.svh
// ----------------------------------------------------------------------------
// text console char engine assertion macros
// shared concurrent assertion forms, clocked on clock, off during reset
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_ENGINE_CORE_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_ENGINE_CORE_DEFINES_SVH

// same-cycle implication
`define TCCE_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TCCE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// types, codes and constants of the text console char engine
// ----------------------------------------------------------------------------
package tcce_pkg;

   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;

   localparam int IDX_W      = 11;
   localparam int CHAR_W     = 8;
   localparam int COLOR_W    = 4;
   localparam int CELL_W     = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;

   localparam logic CMD_PUT  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_FG_COLOR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_COLOR = 1'b1;

   localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
   localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'd32;
   localparam logic [CELL_W-1:0]  CLEAR_CELL   = 16'h0720;
   localparam logic [COLOR_W-1:0] FG_RESET     = 4'd7;
   localparam logic [COLOR_W-1:0] BG_RESET     = 4'd0;

   typedef struct packed {
      logic              command;
      logic [CHAR_W-1:0] char_code;
      logic [IDX_W-1:0]  read_index;
   } req_word_type;

   typedef struct packed {
      logic [IDX_W-1:0]  cursor_index;
      logic              cell_written;
      logic [IDX_W-1:0]  written_index;
      logic [CELL_W-1:0] written_entry;
      logic              scrolled;
      logic [CELL_W-1:0] read_entry;
   } rsp_word_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic sweep_run;
      logic clear_mode;
      logic load_rsp;
   } tcce_cmd_type;

   typedef struct packed {
      logic need_scroll;
      logic sweep_done;
   } tcce_status_type;

   function automatic logic [CELL_W-1:0] build_cell(
      input logic [CHAR_W-1:0]  ch,
      input logic [COLOR_W-1:0] fg,
      input logic [COLOR_W-1:0] bg
   );
      return {bg, fg, ch};
   endfunction

endpackage

### src/tcce_ctrl.sv
// ----------------------------------------------------------------------------
// tcce_ctrl
// sequencer: clearing pass, command execution, scroll sweep, response
// ----------------------------------------------------------------------------
`include "text_console_char_engine_core_defines.svh"

module tcce_ctrl
   import tcce_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  tcce_status_type status,
   output tcce_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_EXEC   = 5'b00100,
      ST_SCROLL = 5'b01000,
      ST_RESP   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.sweep_run  = 1'b1;
            cmd.clear_mode = 1'b1;
            if (status.sweep_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.need_scroll ? ST_SCROLL : ST_RESP;
         end
         ST_SCROLL: begin
            cmd.sweep_run = 1'b1;
            if (status.sweep_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            cmd.load_rsp = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   `TCCE_ASSERT_NEXT(a_accept_to_exec, start && !busy, state_ff == ST_EXEC,
      "accepted word did not enter execution")
   `TCCE_ASSERT_NEXT(a_resp_to_idle, state_ff == ST_RESP, !busy,
      "block stayed busy after response")
   `TCCE_ASSERT_NOW(a_sweep_clear_mode, cmd.sweep_run,
      cmd.clear_mode == (state_ff == ST_CLEAR), "sweep mode does not match state")

endmodule

### src/tcce_datapath.sv
// ----------------------------------------------------------------------------
// tcce_datapath
// screen memory, cursor, color registers, sweep counter and response register
// ----------------------------------------------------------------------------
`include "text_console_char_engine_core_defines.svh"

module tcce_datapath
   import tcce_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int ROWS    = ROWS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  req_word_type          req_word,
   input  tcce_cmd_type          cmd,
   output tcce_status_type       status,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_valid,
   output rsp_word_type          rsp_word
);

   localparam int CellCount = ROWS * COLUMNS;
   localparam int CopyCount = CellCount - COLUMNS;
   localparam int AddrW     = $clog2(CellCount);
   localparam int SweepW    = AddrW + 1;
   localparam int PosW      = (AddrW > IDX_W) ? AddrW : IDX_W;
   localparam int RowW      = $clog2(ROWS);
   localparam int ColW      = $clog2(COLUMNS);

   logic [CELL_W-1:0] screen_mem [CellCount];

   req_word_type       item_ff;
   logic [RowW-1:0]    row_ff, row_in;
   logic [ColW-1:0]    col_ff, col_in;
   logic [COLOR_W-1:0] fg_ff, bg_ff;
   logic [SweepW-1:0]  sweep_ff, sweep_in;
   logic [CELL_W-1:0]  rd_data_ff;
   logic               in_range_ff;
   logic               wr_flag_ff;
   logic [IDX_W-1:0]   widx_ff;
   logic [CELL_W-1:0]  wentry_ff;
   logic               scroll_flag_ff;
   logic               rsp_valid_ff;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   logic              mem_we, mem_re;
   logic [AddrW-1:0]  mem_waddr, mem_raddr;
   logic [CELL_W-1:0] mem_wdata;

   logic [PosW-1:0]   cursor_pos, ridx_pos;
   logic              ridx_in_range;
   logic              is_put, is_newline, at_last_col, at_last_row, line_feed;
   logic [CELL_W-1:0] put_cell, blank_cell;
   logic [SweepW-1:0] sweep_prev;
   logic              sweep_done;

   assign cursor_pos = PosW'(row_ff) * PosW'(COLUMNS) + PosW'(col_ff);
   assign ridx_pos   = PosW'(item_ff.read_index);
   assign ridx_in_range = (ridx_pos < PosW'(CellCount));

   assign is_put      = (item_ff.command == CMD_PUT);
   assign is_newline  = (item_ff.char_code == NEWLINE_CODE);
   assign at_last_col = (col_ff == ColW'(COLUMNS - 1));
   assign at_last_row = (row_ff == RowW'(ROWS - 1));
   assign line_feed   = is_newline || at_last_col;

   assign put_cell   = build_cell(item_ff.char_code, fg_ff, bg_ff);
   assign blank_cell = build_cell(SPACE_CODE, fg_ff, bg_ff);

   assign sweep_prev = sweep_ff - SweepW'(1);
   assign sweep_done = (sweep_ff == SweepW'(CellCount));

   assign status.need_scroll = is_put && line_feed && at_last_row;
   assign status.sweep_done  = sweep_done;

   // memory port selection
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = put_cell;
      mem_re    = 1'b0;
      mem_raddr = '0;
      if (cmd.exec) begin
         if (is_put) begin
            mem_we    = !is_newline;
            mem_waddr = cursor_pos[AddrW-1:0];
         end else begin
            mem_re    = 1'b1;
            mem_raddr = ridx_in_range ? ridx_pos[AddrW-1:0] : '0;
         end
      end else if (cmd.sweep_run) begin
         // read a row ahead of the sweep count, write the cell one behind the count
         if (!cmd.clear_mode && (sweep_ff < SweepW'(CopyCount))) begin
            mem_re    = 1'b1;
            mem_raddr = AddrW'(sweep_ff + SweepW'(COLUMNS));
         end
         if (sweep_ff != '0) begin
            mem_we    = 1'b1;
            mem_waddr = sweep_prev[AddrW-1:0];
            if (cmd.clear_mode) begin
               mem_wdata = CLEAR_CELL;
            end else if (sweep_prev < SweepW'(CopyCount)) begin
               mem_wdata = rd_data_ff;
            end else begin
               mem_wdata = blank_cell;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= screen_mem[mem_raddr];
      end
   end

   // cursor update
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (cmd.exec && is_put) begin
         if (line_feed) begin
            col_in = '0;
            if (!at_last_row) begin
               row_in = row_ff + RowW'(1);
            end
         end else begin
            col_in = col_ff + ColW'(1);
         end
      end
   end

   always_comb begin
      sweep_in = sweep_ff;
      if (cmd.exec) begin
         sweep_in = '0;
      end else if (cmd.sweep_run && !sweep_done) begin
         sweep_in = sweep_ff + SweepW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         col_ff   <= '0;
         fg_ff    <= FG_RESET;
         bg_ff    <= BG_RESET;
         sweep_ff <= '0;
      end else begin
         row_ff   <= row_in;
         col_ff   <= col_in;
         sweep_ff <= sweep_in;
         if (csr_write) begin
            case (csr_index)
               CSR_FG_COLOR: fg_ff <= csr_wdata;
               CSR_BG_COLOR: bg_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // item capture and execution record
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_word;
      end
      if (cmd.exec) begin
         in_range_ff    <= ridx_in_range;
         wr_flag_ff     <= is_put && !is_newline;
         widx_ff        <= (is_put && !is_newline) ? cursor_pos[IDX_W-1:0] : '0;
         wentry_ff      <= (is_put && !is_newline) ? put_cell : '0;
         scroll_flag_ff <= is_put && line_feed && at_last_row;
      end
   end

   always_comb begin
      rsp_word_in.cursor_index  = cursor_pos[IDX_W-1:0];
      rsp_word_in.cell_written  = wr_flag_ff;
      rsp_word_in.written_index = widx_ff;
      rsp_word_in.written_entry = wentry_ff;
      rsp_word_in.scrolled      = scroll_flag_ff;
      rsp_word_in.read_entry    = (!is_put && in_range_ff) ? rd_data_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.load_rsp;
      end
      if (cmd.load_rsp) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `TCCE_ASSERT_NOW(a_write_in_range, mem_we,
      PosW'(mem_waddr) < PosW'(CellCount), "memory write beyond the screen")
   `TCCE_ASSERT_NEXT(a_strobe_single, rsp_valid_ff, !rsp_valid_ff,
      "result strobe held for more than one cycle")
   `TCCE_ASSERT_NEXT(a_scroll_keeps_row, cmd.exec && status.need_scroll,
      at_last_row && (col_ff == '0), "scroll moved cursor off the last row start")

endmodule

### src/text_console_char_engine_core.sv
// ----------------------------------------------------------------------------
// text_console_char_engine_core
// text console character engine: cell store, cursor, scroll and cell read-out
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. A put, a newline or a
// read runs through an execute state against the screen memory and a response
// state that forms the result, whose strobe rsp_valid is high for one cycle
// right after. A put or newline that moves down from the last row adds a
// scroll sweep over ROWS*COLUMNS cells between them, with the screen memory
// copying one cell per cycle through its single read and write port.
// After reset busy stays high for a clearing pass that fills the screen with
// grey spaces; color writes are taken meanwhile.
// The result cannot be stalled, so a receiver must take it in that cycle.
// ----------------------------------------------------------------------------
module text_console_char_engine_core
   import tcce_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int ROWS    = ROWS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_word_type          req_word,
   output logic                  rsp_valid,
   output rsp_word_type          rsp_word,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   tcce_cmd_type    cmd;
   tcce_status_type status;

   tcce_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   tcce_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .status    (status),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

### sim/tb_text_console_char_engine_core.sv
// ----------------------------------------------------------------------------
// tb_text_console_char_engine_core
// Drives put and read words into the text console engine and checks every
// result word against a shadow copy of the screen, the cursor and the colors,
// or against a hand-checked word. A short table of words, most hand-checked,
// runs first. Random phases with different color settings follow, with line
// fills that force wraps and scrolls and, in most phases, random start gaps.
// ----------------------------------------------------------------------------
module tb_text_console_char_engine_core;
   import tcce_pkg::*;

   localparam int COLS  = COLUMNS_DEF;
   localparam int LINES = ROWS_DEF;
   localparam int CELLS = COLS * LINES;

   typedef struct {
      req_word_type word;
      bit           typed;
      rsp_word_type resp;
   } plan_row_type;

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   req_word_type          req_word  = '0;
   logic                  rsp_valid;
   rsp_word_type          rsp_word;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_FG_COLOR;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow of the screen, cursor and colors
   logic [CELL_W-1:0]  shadow_screen [CELLS];
   int                 cur_row;
   int                 cur_col;
   logic [COLOR_W-1:0] fg_now;
   logic [COLOR_W-1:0] bg_now;

   rsp_word_type expected_rsp [$];
   int           error_count = 0;
   bit           no_gaps     = 1'b0;

   text_console_char_engine_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // move the cursor to the next line, scrolling on the last row
   function automatic logic advance_row();
      if (cur_row < LINES - 1) begin
         cur_row++;
         cur_col = 0;
         return 1'b0;
      end
      for (int i = 0; i < CELLS - COLS; i++) begin
         shadow_screen[i] = shadow_screen[i + COLS];
      end
      for (int i = CELLS - COLS; i < CELLS; i++) begin
         shadow_screen[i] = {bg_now, fg_now, SPACE_CODE};
      end
      cur_col = 0;
      return 1'b1;
   endfunction

   function automatic rsp_word_type console_step(input req_word_type w);
      rsp_word_type r;
      int           pos;
      r = '0;
      if (w.command == CMD_READ) begin
         if (w.read_index < CELLS) r.read_entry = shadow_screen[w.read_index];
      end else if (w.char_code == NEWLINE_CODE) begin
         r.scrolled = advance_row();
      end else begin
         pos = cur_row * COLS + cur_col;
         shadow_screen[pos] = {bg_now, fg_now, w.char_code};
         r.cell_written  = 1'b1;
         r.written_index = IDX_W'(pos);
         r.written_entry = shadow_screen[pos];
         cur_col++;
         if (cur_col == COLS) r.scrolled = advance_row();
      end
      r.cursor_index = IDX_W'(cur_row * COLS + cur_col);
      return r;
   endfunction

   task automatic note_failure(input string what);
      error_count++;
      if (error_count <= 10) $display("%t: %s", $realtime, what);
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         note_failure($sformatf("%s mismatch: expected %0h, got %0h", name, want, got));
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            note_failure($sformatf("unexpected result word %h", rsp_word));
         end else begin
            want = expected_rsp.pop_front();
            check_field("cursor_index",  rsp_word.cursor_index,  want.cursor_index);
            check_field("cell_written",  rsp_word.cell_written,  want.cell_written);
            check_field("written_index", rsp_word.written_index, want.written_index);
            check_field("written_entry", rsp_word.written_entry, want.written_entry);
            check_field("scrolled",      rsp_word.scrolled,      want.scrolled);
            check_field("read_entry",    rsp_word.read_entry,    want.read_entry);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   // holds start high until the word is taken, then logs what should come back
   task automatic issue_word(input req_word_type w, input bit typed,
                             input rsp_word_type typed_rsp);
      int           gap;
      rsp_word_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      predicted = console_step(w);
      expected_rsp.push_back(typed ? typed_rsp : predicted);
   endtask

   // color writes only once the engine has drained
   task automatic set_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
      start <= 1'b0;
      while (expected_rsp.size() != 0 || busy) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_FG_COLOR;
      csr_wdata <= fg;
      @(posedge clock);
      csr_index <= CSR_BG_COLOR;
      csr_wdata <= bg;
      @(posedge clock);
      csr_write <= 1'b0;
      fg_now = fg;
      bg_now = bg;
   endtask

   initial begin
      plan_row_type       plan [$];
      req_word_type       w;
      int                 roll;
      int                 fill;
      int                 count;
      logic [COLOR_W-1:0] fg_pick;
      logic [COLOR_W-1:0] bg_pick;

      foreach (shadow_screen[i]) shadow_screen[i] = CLEAR_CELL;
      cur_row = 0;
      cur_col = 0;
      fg_now  = FG_RESET;
      bg_now  = BG_RESET;

      // table rows first, mostly hand-checked, with reset colors
      plan.push_back('{'{CMD_READ, 8'h00, 11'd0},    1'b1, '{11'd0, 1'b0, 11'd0, 16'h0, 1'b0, CLEAR_CELL}});
      plan.push_back('{'{CMD_READ, 8'h00, 11'd1999}, 1'b1, '{11'd0, 1'b0, 11'd0, 16'h0, 1'b0, CLEAR_CELL}});
      plan.push_back('{'{CMD_READ, 8'h00, 11'd2000}, 1'b1, '{11'd0, 1'b0, 11'd0, 16'h0, 1'b0, 16'h0}});
      plan.push_back('{'{CMD_READ, 8'hff, 11'd2047}, 1'b1, '{11'd0, 1'b0, 11'd0, 16'h0, 1'b0, 16'h0}});
      plan.push_back('{'{CMD_PUT,  8'h41, 11'd2047}, 1'b1, '{11'd1, 1'b1, 11'd0, 16'h0741, 1'b0, 16'h0}});
      plan.push_back('{'{CMD_PUT,  8'h00, 11'd0},    1'b1, '{11'd2, 1'b1, 11'd1, 16'h0700, 1'b0, 16'h0}});
      plan.push_back('{'{CMD_PUT,  8'hff, 11'd0},    1'b1, '{11'd3, 1'b1, 11'd2, 16'h07ff, 1'b0, 16'h0}});
      plan.push_back('{'{CMD_READ, 8'h00, 11'd2},    1'b1, '{11'd3, 1'b0, 11'd0, 16'h0, 1'b0, 16'h07ff}});
      plan.push_back('{'{CMD_PUT,  NEWLINE_CODE, 11'h555}, 1'b1, '{11'd80, 1'b0, 11'd0, 16'h0, 1'b0, 16'h0}});
      plan.push_back('{'{CMD_PUT,  8'h80, 11'd0},    1'b1, '{11'd81, 1'b1, 11'd80, 16'h0780, 1'b0, 16'h0}});
      plan.push_back('{'{CMD_PUT,  SPACE_CODE, 11'd0}, 1'b1, '{11'd82, 1'b1, 11'd81, 16'h0720, 1'b0, 16'h0}});
      plan.push_back('{'{CMD_READ, NEWLINE_CODE, 11'd80}, 1'b1, '{11'd82, 1'b0, 11'd0, 16'h0, 1'b0, 16'h0780}});
      plan.push_back('{'{CMD_PUT,  NEWLINE_CODE, 11'd0}, 1'b1, '{11'd160, 1'b0, 11'd0, 16'h0, 1'b0, 16'h0}});
      plan.push_back('{'{CMD_PUT,  NEWLINE_CODE, 11'h7ff}, 1'b1, '{11'd240, 1'b0, 11'd0, 16'h0, 1'b0, 16'h0}});
      plan.push_back('{'{CMD_READ, 8'h00, 11'd1},    1'b1, '{11'd240, 1'b0, 11'd0, 16'h0, 1'b0, 16'h0700}});
      plan.push_back('{'{CMD_PUT,  8'h7f, 11'd0},    1'b1, '{11'd241, 1'b1, 11'd240, 16'h077f, 1'b0, 16'h0}});
      plan.push_back('{'{CMD_PUT,  8'h0b, 11'd0},    1'b0, '0});
      plan.push_back('{'{CMD_PUT,  8'h09, 11'd1234}, 1'b0, '0});
      plan.push_back('{'{CMD_READ, 8'h55, 11'd241},  1'b0, '0});
      plan.push_back('{'{CMD_READ, 8'haa, 11'd1024}, 1'b0, '0});

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) issue_word(plan[i].word, plan[i].typed, plan[i].resp);

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            1: begin fg_pick = 4'hf; bg_pick = 4'hf; end
            2: begin fg_pick = 4'h0; bg_pick = 4'h0; end
            3: begin fg_pick = 4'hf; bg_pick = 4'h0; end
            4: begin fg_pick = 4'h0; bg_pick = 4'hf; end
            default: begin
               fg_pick = COLOR_W'($urandom_range(0, 15));
               bg_pick = COLOR_W'($urandom_range(0, 15));
            end
         endcase
         if (ph > 0) set_colors(fg_pick, bg_pick);
         no_gaps = (ph % 3 == 2);
         count   = 0;
         while (count < 160) begin
            roll         = $urandom_range(0, 99);
            w.command    = CMD_PUT;
            w.char_code  = CHAR_W'($urandom_range(0, 255));
            w.read_index = IDX_W'($urandom_range(0, 2047));
            if (roll < 2) begin
               // run of printable chars up to the end of the row, forcing a wrap
               fill = COLS - cur_col;
               repeat (fill) begin
                  w.char_code  = CHAR_W'($urandom_range(32, 126));
                  w.read_index = IDX_W'($urandom_range(0, 2047));
                  issue_word(w, 1'b0, '0);
               end
               count += fill;
            end else begin
               if (roll < 12) begin
                  w.command = CMD_READ;
                  if (roll < 10) w.read_index = IDX_W'($urandom_range(0, CELLS - 1));
                  else w.read_index = IDX_W'($urandom_range(CELLS, 2047));
               end else if (roll < 17) begin
                  w.char_code = NEWLINE_CODE;
               end
               issue_word(w, 1'b0, '0);
               count++;
            end
         end
      end

      start <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      // a late or extra word would show up within one scroll sweep
      repeat (CELLS + 100) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
